>>> src/olpd_pkg.sv
// Shared types and constants for the ordered list unit.
package olpd_pkg;

	// Size of the row of cells and the widths that follow from it.
	localparam int CAPACITY = 16;
	localparam int CNT_W    = $clog2(CAPACITY + 1);
	localparam int IDX_W    = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
	localparam int DATA_W   = 32;
	localparam int POS_W    = 8;

	// Operation codes of a request.
	typedef enum logic [1:0] {
		OP_INSERT_FRONT = 2'd0,
		OP_REMOVE_FRONT = 2'd1,
		OP_REMOVE_BACK  = 2'd2,
		OP_REMOVE_AT    = 2'd3
	} op_t;

	// Status codes of a result.
	typedef enum logic [1:0] {
		ST_DONE    = 2'd0,
		ST_EMPTY   = 2'd1,
		ST_INVALID = 2'd2,
		ST_FULL    = 2'd3
	} status_t;

	// Per-cell move: keep, take the entry in front, or take the entry behind.
	typedef enum logic [1:0] {
		CELL_HOLD  = 2'd0,
		CELL_BACK  = 2'd1,
		CELL_FWD   = 2'd2
	} cell_cmd_t;

	// Result bookkeeping handed from the controller to the top level.
	typedef struct packed {
		logic             done;
		status_t          status;
		logic [CNT_W-1:0] count;
	} res_t;

endpackage

>>> src/olpd_cell.sv
// One storage cell of the list row.
module olpd_cell (
	input  logic                        clk,
	input  olpd_pkg::cell_cmd_t         cmd,
	input  logic [olpd_pkg::DATA_W-1:0] back_in,
	input  logic [olpd_pkg::DATA_W-1:0] fwd_in,
	output logic [olpd_pkg::DATA_W-1:0] data_q
);

	// Take the entry in front on an insert, the one behind when a gap closes.
	always_ff @(posedge clk) begin
		unique case (cmd)
			olpd_pkg::CELL_BACK: data_q <= back_in;
			olpd_pkg::CELL_FWD:  data_q <= fwd_in;
			default:             data_q <= data_q;
		endcase
	end

endmodule

>>> src/olpd_ctrl.sv
// Request decoder: checks the request, keeps the count and steers the cells.
module olpd_ctrl (
	input  logic                                         clk,
	input  logic                                         arst_n,
	input  logic                                         accept,
	input  logic [1:0]                                   operation,
	input  logic [olpd_pkg::POS_W-1:0]                   position,
	output olpd_pkg::cell_cmd_t [olpd_pkg::CAPACITY-1:0] cmds,
	output olpd_pkg::res_t                               res
);

	logic [olpd_pkg::CNT_W-1:0] occ_q;
	logic [olpd_pkg::CNT_W-1:0] occ_d;
	olpd_pkg::status_t          status_q;
	olpd_pkg::status_t          status_d;
	logic                       done_q;
	logic                       insert_ok;
	logic                       remove_ok;
	logic                       shift_ok;
	logic [olpd_pkg::POS_W-1:0] gap_idx;
	logic                       pos_ok;
	olpd_pkg::op_t              op;

	assign op     = olpd_pkg::op_t'(operation);
	assign pos_ok = (position != '0) &&
		({1'b0, position} <= (olpd_pkg::POS_W + 1)'(occ_q));

	// Decide the outcome of the request and the new count.
	always_comb begin
		insert_ok = 1'b0;
		remove_ok = 1'b0;
		shift_ok  = 1'b0;
		gap_idx   = '0;
		status_d  = olpd_pkg::ST_DONE;
		unique case (op)
			olpd_pkg::OP_INSERT_FRONT: begin
				if (occ_q >= olpd_pkg::CNT_W'(olpd_pkg::CAPACITY)) begin
					status_d = olpd_pkg::ST_FULL;
				end else begin
					insert_ok = 1'b1;
				end
			end
			olpd_pkg::OP_REMOVE_FRONT: begin
				if (occ_q == '0) begin
					status_d = olpd_pkg::ST_EMPTY;
				end else begin
					remove_ok = 1'b1;
					shift_ok  = 1'b1;
				end
			end
			olpd_pkg::OP_REMOVE_BACK: begin
				if (occ_q == '0) begin
					status_d = olpd_pkg::ST_EMPTY;
				end else begin
					remove_ok = 1'b1;
				end
			end
			default: begin
				if (!pos_ok) begin
					status_d = olpd_pkg::ST_INVALID;
				end else begin
					remove_ok = 1'b1;
					shift_ok  = 1'b1;
					gap_idx   = position - 1'b1;
				end
			end
		endcase
		occ_d = occ_q;
		if (accept && insert_ok) begin
			occ_d = occ_q + 1'b1;
		end else if (accept && remove_ok) begin
			occ_d = occ_q - 1'b1;
		end
	end

	// Per-cell moves: an insert shifts the whole row back, a removal at the front
	// or at a position closes the gap from the removed cell onward. The last cell has nothing behind.
	always_comb begin
		for (int i = 0; i < olpd_pkg::CAPACITY; i++) begin
			cmds[i] = olpd_pkg::CELL_HOLD;
			if (accept && insert_ok) begin
				cmds[i] = olpd_pkg::CELL_BACK;
			end else if (accept && shift_ok && (i < olpd_pkg::CAPACITY - 1) &&
					(olpd_pkg::POS_W'(i) >= gap_idx)) begin
				cmds[i] = olpd_pkg::CELL_FWD;
			end
		end
	end

	// Count and result registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			occ_q    <= '0;
			done_q   <= 1'b0;
			status_q <= olpd_pkg::ST_DONE;
		end else begin
			occ_q  <= occ_d;
			done_q <= accept;
			if (accept) begin
				status_q <= status_d;
			end
		end
	end

	assign res.done   = done_q;
	assign res.status = status_q;
	assign res.count  = occ_q;

endmodule

>>> src/ordered_list_with_positional_delete_unit.sv
// Ordered list unit: a row of cells that shifts on insert and closes gaps on removal.
// The result strobes on done in the cycle after the request is accepted.
// Throughput: one request per cycle; each cell moves one step per cycle, so an
// insert or a removal anywhere in the row moves every cell at most one step.
// busy is never raised, and results cannot be held off by the receiver.
// Reset clears the entry count and the result strobe; cell contents are undefined.
module ordered_list_with_positional_delete_unit (
	input  logic                                      clk,
	input  logic                                      arst_n,
	input  logic                                      start,
	output logic                                      busy,
	input  logic [1:0]                                operation,
	input  logic signed [olpd_pkg::DATA_W-1:0]        value,
	input  logic [olpd_pkg::POS_W-1:0]                position,
	output logic                                      done,
	output logic [1:0]                                status,
	output logic [olpd_pkg::CNT_W-1:0]                entry_count,
	output logic signed [olpd_pkg::DATA_W-1:0]        front_value,
	output logic signed [olpd_pkg::DATA_W-1:0]        back_value
);

	olpd_pkg::cell_cmd_t [olpd_pkg::CAPACITY-1:0] cmds;
	olpd_pkg::res_t                               res;
	logic [olpd_pkg::DATA_W-1:0]                  cell_data [olpd_pkg::CAPACITY];
	logic [olpd_pkg::IDX_W-1:0]                   back_idx;
	logic                                         accept;

	assign busy   = 1'b0;
	assign accept = start && !busy;

	olpd_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.accept    (accept),
		.operation (operation),
		.position  (position),
		.cmds      (cmds),
		.res       (res)
	);

	// The row of cells; cell 0 is the front and takes the new value on insert.
	for (genvar i = 0; i < olpd_pkg::CAPACITY; i++) begin : g_cell
		logic [olpd_pkg::DATA_W-1:0] back_in;
		logic [olpd_pkg::DATA_W-1:0] fwd_in;
		if (i == 0) begin : g_front
			assign back_in = value;
		end else begin : g_mid
			assign back_in = cell_data[i-1];
		end
		if (i == olpd_pkg::CAPACITY - 1) begin : g_last
			assign fwd_in = '0;
		end else begin : g_inner
			assign fwd_in = cell_data[i+1];
		end
		olpd_cell u_cell (
			.clk     (clk),
			.cmd     (cmds[i]),
			.back_in (back_in),
			.fwd_in  (fwd_in),
			.data_q  (cell_data[i])
		);
	end

	// Result: status and count from the controller, ends of the list from the row.
	assign back_idx    = olpd_pkg::IDX_W'(res.count - 1'b1);
	assign done        = res.done;
	assign status      = res.status;
	assign entry_count = res.count;
	assign front_value = (res.count == '0) ? '0 : cell_data[0];
	assign back_value  = (res.count == '0) ? '0 : cell_data[back_idx];

endmodule

>>> sim/ordered_list_with_positional_delete_unit_tb.sv
// Self-checking testbench for the ordered list unit: directed table, then random traffic.
module ordered_list_with_positional_delete_unit_tb;
	timeunit 1ns;
	timeprecision 1ps;

	import olpd_pkg::*;

	localparam int RANDOM_ITEMS = 1350;
	localparam int STALL_LIMIT  = 500;
	localparam int QUIET_FIRST  = 500;
	localparam int QUIET_LAST   = 850;

	// Expected contents of one result.
	typedef struct packed {
		status_t                  status;
		logic [CNT_W-1:0]         count;
		logic signed [DATA_W-1:0] front;
		logic signed [DATA_W-1:0] back;
	} list_result_t;

	// One row of the directed table; reps repeats the row with value + index.
	typedef struct packed {
		op_t                      op;
		logic signed [DATA_W-1:0] val;
		logic [POS_W-1:0]         pos;
		logic [4:0]               reps;
		logic                     typed;
		list_result_t             want;
	} directed_row_t;

	logic                     clk         = 1'b0;
	logic                     arst_n      = 1'b0;
	logic                     start       = 1'b0;
	op_t                      operation   = OP_INSERT_FRONT;
	logic signed [DATA_W-1:0] value       = '0;
	logic [POS_W-1:0]         position    = '0;
	logic                     busy;
	logic                     done;
	logic [1:0]               status;
	logic [CNT_W-1:0]         entry_count;
	logic signed [DATA_W-1:0] front_value;
	logic signed [DATA_W-1:0] back_value;

	// Hand-written expectation that travels with a directed request.
	logic                     req_typed   = 1'b0;
	list_result_t             req_want    = '0;

	// Shadow copy of the list, front in cell 0.
	logic signed [DATA_W-1:0] shadow_cells [CAPACITY];
	int                       shadow_count = 0;

	list_result_t             pending_results [$];
	directed_row_t            script [$];
	int                       n_accepted   = 0;
	int                       n_errors     = 0;
	int                       quiet_cycles = 0;

	ordered_list_with_positional_delete_unit dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.start       (start),
		.busy        (busy),
		.operation   (operation),
		.value       (value),
		.position    (position),
		.done        (done),
		.status      (status),
		.entry_count (entry_count),
		.front_value (front_value),
		.back_value  (back_value)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Apply one request to the shadow list and return what the unit should report.
	function automatic list_result_t apply_to_shadow(op_t op, logic signed [DATA_W-1:0] val,
			logic [POS_W-1:0] pos);
		list_result_t r;
		int           gap;
		int           k;
		r.status = ST_DONE;
		gap = -1;
		case (op)
			OP_INSERT_FRONT: begin
				if (shadow_count >= CAPACITY) begin
					r.status = ST_FULL;
				end else begin
					for (k = shadow_count; k > 0; k--)
						shadow_cells[k] = shadow_cells[k - 1];
					shadow_cells[0] = val;
					shadow_count++;
				end
			end
			OP_REMOVE_FRONT: begin
				if (shadow_count == 0)
					r.status = ST_EMPTY;
				else
					gap = 0;
			end
			OP_REMOVE_BACK: begin
				if (shadow_count == 0)
					r.status = ST_EMPTY;
				else
					shadow_count--;
			end
			default: begin
				if (pos == 0 || int'(pos) > shadow_count)
					r.status = ST_INVALID;
				else
					gap = int'(pos) - 1;
			end
		endcase
		// Close the gap left by a removal.
		if (gap >= 0) begin
			for (k = gap; k + 1 < shadow_count; k++)
				shadow_cells[k] = shadow_cells[k + 1];
			shadow_count--;
		end
		r.count = CNT_W'(shadow_count);
		r.front = (shadow_count == 0) ? '0 : shadow_cells[0];
		r.back  = (shadow_count == 0) ? '0 : shadow_cells[shadow_count - 1];
		return r;
	endfunction

	function automatic directed_row_t row(op_t op, logic signed [DATA_W-1:0] val,
			logic [POS_W-1:0] pos, logic [4:0] reps, logic typed, status_t st,
			logic [CNT_W-1:0] cnt, logic signed [DATA_W-1:0] front,
			logic signed [DATA_W-1:0] back);
		directed_row_t r;
		r.op          = op;
		r.val         = val;
		r.pos         = pos;
		r.reps        = reps;
		r.typed       = typed;
		r.want.status = st;
		r.want.count  = cnt;
		r.want.front  = front;
		r.want.back   = back;
		return r;
	endfunction

	// Check results, predict accepted requests, and watch for a stalled run.
	always @(posedge clk) begin
		list_result_t want;
		list_result_t got;
		logic         activity;
		activity = 1'b0;
		if (done === 1'b1) begin
			activity = 1'b1;
			if (pending_results.size() == 0) begin
				$error("result with no request outstanding: status %0d count %0d",
					status, entry_count);
				n_errors++;
			end else begin
				want = pending_results.pop_front();
				if (status !== want.status) begin
					$error("status: expected %0d, got %0d", want.status, status);
					n_errors++;
				end
				if (entry_count !== want.count) begin
					$error("entry_count: expected %0d, got %0d", want.count, entry_count);
					n_errors++;
				end
				if (front_value !== want.front) begin
					$error("front_value: expected %0d, got %0d", want.front, front_value);
					n_errors++;
				end
				if (back_value !== want.back) begin
					$error("back_value: expected %0d, got %0d", want.back, back_value);
					n_errors++;
				end
			end
		end
		if (arst_n && start && !busy) begin
			activity = 1'b1;
			got = apply_to_shadow(operation, value, position);
			pending_results.push_back(req_typed ? req_want : got);
			n_accepted++;
		end
		if (arst_n) begin
			quiet_cycles = activity ? 0 : quiet_cycles + 1;
			if (quiet_cycles >= STALL_LIMIT) begin
				$display("DONE: errors detected");
				$finish;
			end
		end
	end

	// Drive one request from a falling edge and hold it until it is accepted.
	task automatic send_request(op_t op, logic signed [DATA_W-1:0] val, logic [POS_W-1:0] pos,
			logic typed, list_result_t want, bit may_idle);
		int seen;
		if (may_idle && $urandom_range(99, 0) < 6) begin
			start <= 1'b0;
			repeat ($urandom_range(4, 1)) @(negedge clk);
		end
		start     <= 1'b1;
		operation <= op;
		value     <= val;
		position  <= pos;
		req_typed <= typed;
		req_want  <= want;
		seen = n_accepted;
		do @(negedge clk); while (n_accepted == seen);
	endtask

	initial begin
		directed_row_t            r;
		op_t                      op;
		logic signed [DATA_W-1:0] val;
		logic [POS_W-1:0]         pos;
		bit                       grow;
		int                       pick;
		int                       i;
		int                       k;

		// Empty list, position extremes, value extremes, fill to full, edge removals.
		script.push_back(row(OP_REMOVE_FRONT, 32'sd0, 8'd0, 5'd1, 1'b1, ST_EMPTY, 5'd0, 0, 0));
		script.push_back(row(OP_REMOVE_BACK, -32'sd1, 8'hFF, 5'd1, 1'b1, ST_EMPTY, 5'd0, 0, 0));
		script.push_back(row(OP_REMOVE_AT, 32'sd0, 8'd0, 5'd1, 1'b1, ST_INVALID, 5'd0, 0, 0));
		script.push_back(row(OP_REMOVE_AT, 32'sd0, 8'd1, 5'd1, 1'b1, ST_INVALID, 5'd0, 0, 0));
		script.push_back(row(OP_REMOVE_AT, -32'sd1, 8'hFF, 5'd1, 1'b1, ST_INVALID, 5'd0, 0, 0));
		script.push_back(row(OP_INSERT_FRONT, 32'h7FFF_FFFF, 8'd0, 5'd1, 1'b1, ST_DONE, 5'd1,
			32'h7FFF_FFFF, 32'h7FFF_FFFF));
		script.push_back(row(OP_INSERT_FRONT, 32'h8000_0000, 8'hFF, 5'd1, 1'b1, ST_DONE, 5'd2,
			32'h8000_0000, 32'h7FFF_FFFF));
		script.push_back(row(OP_REMOVE_AT, 32'sd0, 8'd3, 5'd1, 1'b1, ST_INVALID, 5'd2,
			32'h8000_0000, 32'h7FFF_FFFF));
		script.push_back(row(OP_REMOVE_AT, 32'sd0, 8'd2, 5'd1, 1'b1, ST_DONE, 5'd1,
			32'h8000_0000, 32'h8000_0000));
		script.push_back(row(OP_REMOVE_BACK, 32'sd0, 8'd0, 5'd1, 1'b1, ST_DONE, 5'd0, 0, 0));
		script.push_back(row(OP_INSERT_FRONT, 32'sd1000, 8'd0, 5'd16, 1'b0, ST_DONE, 5'd0,
			0, 0));
		script.push_back(row(OP_INSERT_FRONT, 32'h7FFF_FFFF, 8'd0, 5'd1, 1'b1, ST_FULL, 5'd16,
			32'sd1015, 32'sd1000));
		script.push_back(row(OP_REMOVE_AT, 32'sd0, 8'd16, 5'd1, 1'b0, ST_DONE, 5'd0, 0, 0));
		script.push_back(row(OP_REMOVE_AT, -32'sd1, 8'd1, 5'd1, 1'b0, ST_DONE, 5'd0, 0, 0));
		script.push_back(row(OP_REMOVE_AT, 32'sd0, 8'd7, 5'd1, 1'b0, ST_DONE, 5'd0, 0, 0));
		script.push_back(row(OP_REMOVE_AT, 32'sd0, 8'd14, 5'd1, 1'b0, ST_DONE, 5'd0, 0, 0));
		script.push_back(row(OP_REMOVE_FRONT, -32'sd1, 8'hFF, 5'd1, 1'b0, ST_DONE, 5'd0,
			0, 0));
		script.push_back(row(OP_REMOVE_BACK, 32'sd0, 8'd0, 5'd1, 1'b0, ST_DONE, 5'd0, 0, 0));

		// Reset once, released on a falling edge.
		repeat (5) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// Directed table.
		foreach (script[j]) begin
			r = script[j];
			for (k = 0; k < int'(r.reps); k++)
				send_request(r.op, r.val + k, r.pos, r.typed, r.want, 1'b1);
		end

		// Random traffic that sweeps the list between empty and full.
		grow = 1'b1;
		for (i = 0; i < RANDOM_ITEMS; i++) begin
			if (shadow_count == 0)
				grow = 1'b1;
			else if (shadow_count == CAPACITY && $urandom_range(3, 0) == 0)
				grow = 1'b0;
			else if ($urandom_range(99, 0) < 2)
				grow = !grow;

			pick = $urandom_range(99, 0);
			if (pick < (grow ? 60 : 28)) begin
				op = OP_INSERT_FRONT;
			end else begin
				case ($urandom_range(3, 0))
					0:       op = OP_REMOVE_FRONT;
					1:       op = OP_REMOVE_BACK;
					default: op = OP_REMOVE_AT;
				endcase
			end

			pick = $urandom_range(99, 0);
			if (pick < 85)
				val = $urandom;
			else if (pick < 89)
				val = 32'h7FFF_FFFF;
			else if (pick < 93)
				val = 32'h8000_0000;
			else if (pick < 97)
				val = '0;
			else
				val = -32'sd1;

			// Mostly positions inside the list, some just outside, some anywhere.
			pick = $urandom_range(99, 0);
			if (shadow_count > 0 && pick < 80)
				pos = POS_W'($urandom_range(shadow_count, 1));
			else if (pick < 90)
				pos = $urandom_range(1, 0) ? '0 : POS_W'(shadow_count + $urandom_range(2, 1));
			else
				pos = POS_W'($urandom_range(255, 0));

			send_request(op, val, pos, 1'b0, '0, (i < QUIET_FIRST || i >= QUIET_LAST));
		end
		start <= 1'b0;

		// Drain outstanding results, then allow for the result latency.
		while (pending_results.size() != 0)
			@(negedge clk);
		repeat (4) @(negedge clk);

		if (n_errors == 0)
			$display("DONE: 0 errors");
		else
			$display("DONE: errors detected");
		$finish;
	end

endmodule
